// ===== hdl/rtp_packet_header_checker_assert.svh =====
// assertion macros used by the checker file
`ifndef RTP_PACKET_HEADER_CHECKER_ASSERT_SVH
`define RTP_PACKET_HEADER_CHECKER_ASSERT_SVH

// checked only while out of reset
`define RTP_PHC_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);

// checked at every edge, reset included
`define RTP_PHC_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) expr) else $error(msg);

`endif

// ===== hdl/rtp_phc_pkg.sv =====
// types, codes and constants of the rtp packet header checker
package rtp_phc_pkg;

   localparam int unsigned HdrFixed   = 12;
   localparam int unsigned WordBytes  = 4;
   localparam int unsigned OffsetBits = 19;
   localparam int unsigned PtBits     = 7;
   localparam int unsigned ReqBits    = 96;
   localparam int unsigned RspBits    = 80;
   localparam int unsigned CsrBits    = 64;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_PADDING   = 3'd3,
      ST_TRUNC_EXT = 3'd4,
      ST_NO_DEC    = 3'd5,
      ST_HDR_LONG  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      FA_NONE   = 2'd0,
      FA_FINISH = 2'd1,
      FA_CANCEL = 2'd2
   } action_type;

   typedef enum logic {
      CSR_PT_LOW  = 1'b0,
      CSR_PT_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] packet_length;
      logic [15:0] ext_length;
      logic [31:0] rtp_time;
      logic [31:0] header_word;
   } item_type;

   typedef struct packed {
      action_type            frame_action;
      logic [31:0]           time_out;
      logic [15:0]           seq_out;
      logic [PtBits-1:0]     payload_kind;
      logic [OffsetBits-1:0] payload_offset;
      logic                  deliver;
      status_type            status;
   } result_type;

   typedef struct packed {
      logic [CsrBits-1:0] pt_low;
      logic [CsrBits-1:0] pt_high;
   } pt_map_type;

endpackage

// ===== hdl/rtp_phc_csr.sv =====
// payload type bitmap registers written through the csr port
module rtp_phc_csr
   import rtp_phc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  csr_index_type      csr_addr,
   input  logic [CsrBits-1:0] csr_wdata,
   output pt_map_type         pt_map
);

   logic [CsrBits-1:0] pt_low_ff,  pt_low_in;
   logic [CsrBits-1:0] pt_high_ff, pt_high_in;

   always_comb begin
      pt_low_in  = pt_low_ff;
      pt_high_in = pt_high_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PT_LOW:  pt_low_in  = csr_wdata;
            CSR_PT_HIGH: pt_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_low_ff  <= '0;
         pt_high_ff <= '0;
      end else begin
         pt_low_ff  <= pt_low_in;
         pt_high_ff <= pt_high_in;
      end
   end

   assign pt_map.pt_low  = pt_low_ff;
   assign pt_map.pt_high = pt_high_ff;

endmodule

// ===== hdl/rtp_phc_eval.sv =====
// header checks, sequence tracking and frame state for one item per cycle while advance is high
module rtp_phc_eval
   import rtp_phc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  pt_map_type pt_map,
   output result_type result
);

   logic        seen_first_ff, seen_first_in;
   logic [15:0] prev_seq_ff,   prev_seq_in;
   logic        frame_ok_ff,   frame_ok_in;

   logic [15:0]           seq;
   logic [PtBits-1:0]     pt;
   logic                  marker, xbit, pbit;
   logic [3:0]            cc;
   logic [15:0]           len;
   logic [15:0]           prev_eff;
   logic [15:0]           delta;
   logic                  too_short, dup, trunc, passed;
   logic [6:0]            hbase;
   logic [OffsetBits-1:0] hsize;
   logic                  pt_ok, fok_mid, hdr_long, handle;

   always_comb begin
      seq    = item.header_word[15:0];
      pt     = item.header_word[22:16];
      marker = item.header_word[23];
      cc     = item.header_word[27:24];
      xbit   = item.header_word[28];
      pbit   = item.header_word[29];
      len    = item.packet_length;

      too_short = len < 16'(HdrFixed);
      // first packet primes the previous number so it is never a gap
      prev_eff  = seen_first_ff ? prev_seq_ff : seq - 16'd1;
      delta     = seq - prev_eff;
      dup       = delta == 16'd0;

      hbase = 7'(HdrFixed) + {cc, 2'b00};
      trunc = xbit && ({1'b0, len} < ({10'd0, hbase} + 17'(WordBytes)));
      hsize = xbit ? OffsetBits'(hbase) + OffsetBits'(WordBytes)
                     + {1'b0, item.ext_length, 2'b00}
                   : OffsetBits'(hbase);

      passed   = !too_short && !dup && !pbit && !trunc;
      pt_ok    = pt[PtBits-1] ? pt_map.pt_high[pt[5:0]] : pt_map.pt_low[pt[5:0]];
      fok_mid  = frame_ok_ff && (delta == 16'd1);
      hdr_long = fok_mid && (hsize >= {3'd0, len});
      handle   = passed && pt_ok && !hdr_long;

      result.seq_out        = seq;
      result.payload_kind   = pt;
      result.payload_offset = passed ? hsize : '0;
      result.deliver        = passed && pt_ok && fok_mid && !hdr_long;
      result.time_out       = result.deliver ? item.rtp_time : '0;
      result.frame_action   = FA_NONE;
      if (handle && marker) begin
         result.frame_action = fok_mid ? FA_FINISH : FA_CANCEL;
      end

      if (too_short) begin
         result.status = ST_SHORT;
      end else if (dup) begin
         result.status = ST_DUPLICATE;
      end else if (pbit) begin
         result.status = ST_PADDING;
      end else if (trunc) begin
         result.status = ST_TRUNC_EXT;
      end else if (!pt_ok) begin
         result.status = ST_NO_DEC;
      end else if (hdr_long) begin
         result.status = ST_HDR_LONG;
      end else begin
         result.status = ST_OK;
      end

      seen_first_in = seen_first_ff;
      prev_seq_in   = prev_seq_ff;
      frame_ok_in   = frame_ok_ff;
      if (advance && !too_short) begin
         seen_first_in = 1'b1;
         prev_seq_in   = passed ? seq : prev_eff;
         if (passed) begin
            frame_ok_in = (handle && marker) ? 1'b1 : fok_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff <= 1'b0;
         prev_seq_ff   <= '0;
         frame_ok_ff   <= 1'b1;
      end else begin
         seen_first_ff <= seen_first_in;
         prev_seq_ff   <= prev_seq_in;
         frame_ok_ff   <= frame_ok_in;
      end
   end

endmodule

// ===== hdl/rtp_packet_header_checker.sv =====
// rtp packet header checker top level: input register, checks, result register
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata: header word, timestamp, ext length, length
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: check outcome, rsp_tuser: payload type
//   csr      in   csr_we                 csr_addr, csr_wdata: payload type bitmaps
//
// one item per cycle while rsp is not stalled; a taken item reaches rsp through
// the input register, then the checks and the sequence state into the result register
// synchronous active-high reset empties both registers and clears the sequence state
// a stalled rsp holds its item; req keeps taking items while the input register is empty or can move on
module rtp_packet_header_checker
   import rtp_phc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // header_word[31:0], rtp_time[63:32], ext_length[79:64], packet_length[95:80]
   input  logic [ReqBits-1:0] req_tdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   // status[2:0], deliver[3], payload_offset[22:4], seq_out[38:23],
   // time_out[70:39], frame_action[72:71], zero[79:73]
   output logic [RspBits-1:0] rsp_tdata,
   // payload_kind[6:0]
   output logic [PtBits-1:0]  rsp_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               csr_we,
   input  csr_index_type      csr_addr,
   input  logic [CsrBits-1:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff,  in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff,   out_res_in;

   pt_map_type pt_map;
   result_type eval_res;
   logic       advance;
   logic       req_fire;

   rtp_phc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .pt_map    (pt_map)
   );

   rtp_phc_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .pt_map  (pt_map),
      .result  (eval_res)
   );

   always_comb begin
      // the item in the input register moves on when the result register frees
      advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready = !in_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;

      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_item_in.header_word   = req_tdata[31:0];
         in_item_in.rtp_time      = req_tdata[63:32];
         in_item_in.ext_length    = req_tdata[79:64];
         in_item_in.packet_length = req_tdata[95:80];
      end

      out_valid_in = advance ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
      out_res_in   = advance ? eval_res : out_res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.payload_kind;
   assign rsp_tdata  = {7'd0,
                        out_res_ff.frame_action,
                        out_res_ff.time_out,
                        out_res_ff.seq_out,
                        out_res_ff.payload_offset,
                        out_res_ff.deliver,
                        out_res_ff.status};

endmodule

// ===== hdl/rtp_phc_checker.sv =====
// port-level checks for the rtp packet header checker, bound to the top level
`include "rtp_packet_header_checker_assert.svh"

module rtp_phc_checker
   import rtp_phc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic [RspBits-1:0] rsp_tdata,
   input logic               rsp_tvalid,
   input logic               rsp_tready
);

   logic [2:0]  rsp_status;
   logic        stalled;
   logic        delivered;
   logic        early_reject;
   logic        reject_clean;
   logic [31:0] rsp_stamp;

   assign rsp_status   = rsp_tdata[2:0];
   assign stalled      = rsp_tvalid && !rsp_tready;
   assign delivered    = rsp_tvalid && rsp_tdata[3];
   assign rsp_stamp    = rsp_tdata[70:39];
   assign early_reject = rsp_tvalid && (rsp_status == ST_SHORT || rsp_status == ST_DUPLICATE
                                        || rsp_status == ST_PADDING
                                        || rsp_status == ST_TRUNC_EXT);
   assign reject_clean = rsp_tdata[22:4] == '0 && rsp_tdata[72:71] == FA_NONE;

   `RTP_PHC_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_tvalid, "rsp valid after reset")
   `RTP_PHC_ASSERT(a_rsp_hold, stalled |=> rsp_tvalid && $stable(rsp_tdata), "stalled item changed")
   `RTP_PHC_ASSERT(a_deliver_ok, delivered |-> rsp_status == ST_OK, "delivered item with bad status")
   `RTP_PHC_ASSERT(a_time_zero, rsp_tvalid && !rsp_tdata[3] |-> rsp_stamp == 32'd0, "stray timestamp")
   `RTP_PHC_ASSERT(a_reject_offset, early_reject |-> reject_clean, "early reject with offset or action")

endmodule

bind rtp_packet_header_checker rtp_phc_checker u_rtp_phc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== verif/testbench.sv =====
// testbench for the rtp packet header checker: directed table, then random packet streams
module testbench;
   import rtp_phc_pkg::*;

   localparam int ClockHalf      = 10;
   localparam int CycleLimit     = 400000;
   localparam int SettleCycles   = 4;
   localparam int RandomPerPhase = 325;
   localparam int MapPhases      = 6;

   typedef struct {
      status_type            status;
      logic                  deliver;
      logic [OffsetBits-1:0] offset;
      logic [PtBits-1:0]     kind;
      logic [15:0]           seq;
      logic [31:0]           stamp;
      action_type            action;
   } header_verdict_type;

   typedef enum {ROW_ITEM, ROW_MAP} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      item_type           pkt;
      bit                 typed;
      header_verdict_type want;
      csr_index_type      addr;
      logic [CsrBits-1:0] map;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [ReqBits-1:0] req_tdata = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [RspBits-1:0] rsp_tdata;
   logic [PtBits-1:0]  rsp_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic               csr_we = 1'b0;
   csr_index_type      csr_addr = CSR_PT_LOW;
   logic [CsrBits-1:0] csr_wdata = '0;

   // predictor state
   logic [CsrBits-1:0] pt_map_lo = '0;
   logic [CsrBits-1:0] pt_map_hi = '0;
   bit                 seq_primed = 1'b0;
   logic [15:0]        last_seq = '0;
   bit                 frame_valid = 1'b1;

   header_verdict_type verdicts_pending[$];
   stim_row_type       directed_rows[$];

   int fail_count = 0;
   int items_sent = 0;
   int map_writes = 0;
   int deliveries = 0;
   int cycle_count = 0;
   int send_idle_max = 18;
   int rsp_idle_max = 18;

   rtp_packet_header_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(ClockHalf) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rtp_word(input logic [1:0] v, input logic p, input logic x,
                                            input logic [3:0] cc, input logic m,
                                            input logic [6:0] pt, input logic [15:0] seq);
      return {v, p, x, cc, m, pt, seq};
   endfunction

   task automatic predict_header(input item_type pkt, output header_verdict_type v);
      logic [15:0] seq;
      logic [15:0] delta;
      logic [6:0]  pt;
      logic [3:0]  cc;
      logic        mark;
      logic        xb;
      logic        pb;
      int unsigned hsize;
      bit          registered;
      bit          marker_live;
      seq  = pkt.header_word[15:0];
      pt   = pkt.header_word[22:16];
      mark = pkt.header_word[23];
      cc   = pkt.header_word[27:24];
      xb   = pkt.header_word[28];
      pb   = pkt.header_word[29];
      v.status  = ST_OK;
      v.deliver = 1'b0;
      v.offset  = '0;
      v.kind    = pt;
      v.seq     = seq;
      v.stamp   = '0;
      v.action  = FA_NONE;
      if (pkt.packet_length < HdrFixed) begin
         v.status = ST_SHORT;
      end else begin
         // the first packet that is long enough primes the sequence tracker
         if (!seq_primed) begin
            seq_primed = 1'b1;
            last_seq   = seq - 16'd1;
         end
         delta = seq - last_seq;
         if (delta == 16'd0) begin
            v.status = ST_DUPLICATE;
         end else if (pb) begin
            v.status = ST_PADDING;
         end else begin
            hsize = HdrFixed + cc * WordBytes;
            if (xb && pkt.packet_length < hsize + WordBytes) begin
               v.status = ST_TRUNC_EXT;
            end else begin
               if (xb) hsize = hsize + WordBytes + pkt.ext_length * WordBytes;
               marker_live = 1'b1;
               v.offset = hsize[OffsetBits-1:0];
               if (delta != 16'd1) frame_valid = 1'b0;
               last_seq = seq;
               registered = pt[6] ? pt_map_hi[pt[5:0]] : pt_map_lo[pt[5:0]];
               if (!registered) begin
                  v.status = ST_NO_DEC;
                  marker_live = 1'b0;
               end else if (frame_valid) begin
                  if (hsize >= pkt.packet_length) begin
                     v.status = ST_HDR_LONG;
                     marker_live = 1'b0;
                  end else begin
                     v.deliver = 1'b1;
                     v.stamp   = pkt.rtp_time;
                  end
               end
               if (marker_live && mark) begin
                  v.action = frame_valid ? FA_FINISH : FA_CANCEL;
                  frame_valid = 1'b1;
               end
            end
         end
      end
   endtask

   task automatic add_typed(input logic [31:0] hw, input logic [31:0] ts, input logic [15:0] ext,
                            input logic [15:0] len, input status_type st, input logic dl,
                            input logic [OffsetBits-1:0] off, input action_type act);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.pkt  = '{packet_length: len, ext_length: ext, rtp_time: ts, header_word: hw};
      row.typed = 1'b1;
      row.want.status  = st;
      row.want.deliver = dl;
      row.want.offset  = off;
      row.want.kind    = hw[22:16];
      row.want.seq     = hw[15:0];
      row.want.stamp   = dl ? ts : 32'd0;
      row.want.action  = act;
      directed_rows.push_back(row);
   endtask

   task automatic add_free(input logic [31:0] hw, input logic [31:0] ts, input logic [15:0] ext,
                           input logic [15:0] len);
      stim_row_type row;
      row.kind  = ROW_ITEM;
      row.pkt   = '{packet_length: len, ext_length: ext, rtp_time: ts, header_word: hw};
      row.typed = 1'b0;
      directed_rows.push_back(row);
   endtask

   task automatic add_map(input csr_index_type addr, input logic [CsrBits-1:0] map);
      stim_row_type row;
      row.kind = ROW_MAP;
      row.addr = addr;
      row.map  = map;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge; returns at a falling edge with nothing in flight
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdicts_pending.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_pt_map(input csr_index_type addr, input logic [CsrBits-1:0] map);
      wait_drained();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= map;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_PT_LOW) pt_map_lo = map;
      else pt_map_hi = map;
      map_writes++;
   endtask

   task automatic send_item(input item_type pkt, input bit typed, input header_verdict_type want);
      header_verdict_type v;
      int gap;
      gap = $urandom_range(0, send_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pkt;
      do @(posedge clock); while (!req_tready);
      predict_header(pkt, v);
      if (typed) v = want;
      verdicts_pending.push_back(v);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic take_result(input logic [RspBits-1:0] data, input logic [PtBits-1:0] kind);
      header_verdict_type v;
      if (verdicts_pending.size() == 0) begin
         $error("result item with no expectation waiting");
         fail_count++;
      end else begin
         v = verdicts_pending.pop_front();
         check_field("status", v.status, data[2:0]);
         check_field("deliver", v.deliver, data[3]);
         check_field("payload_offset", v.offset, data[22:4]);
         check_field("payload_kind", v.kind, kind);
         check_field("seq_out", v.seq, data[38:23]);
         check_field("time_out", v.stamp, data[70:39]);
         check_field("frame_action", v.action, data[72:71]);
         if (v.deliver) deliveries++;
      end
   endtask

   // result side
   initial begin
      int stall;
      int taken;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 50 == 0) rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         take_result(rsp_tdata, rsp_tuser);
         taken++;
         @(negedge clock);
      end
   end

   // packet side
   initial begin
      item_type           pkt;
      header_verdict_type none;
      logic [15:0]        seq;
      logic [15:0]        ext;
      logic [3:0]         cc;
      logic               xb;
      logic [CsrBits-1:0] lo_map;
      logic [CsrBits-1:0] hi_map;
      int                 sel;
      int                 lenv;
      int                 hsize_nom;
      none = '{status: ST_OK, deliver: 1'b0, offset: '0, kind: '0, seq: '0, stamp: '0,
               action: FA_NONE};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bitmaps still at reset: nothing is registered
      add_typed(rtp_word(2, 0, 0, 0, 0, 0, 100), 32'h0000_0000, 16'h0000, 16'd11,
                ST_SHORT, 1'b0, 0, FA_NONE);
      add_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, ST_SHORT, 1'b0, 0, FA_NONE);
      add_typed(rtp_word(2, 0, 0, 0, 1, 5, 100), 32'h0000_0001, 16'h0000, 16'd100,
                ST_NO_DEC, 1'b0, 12, FA_NONE);
      add_map(CSR_PT_LOW, '1);
      add_map(CSR_PT_HIGH, '1);
      add_typed(rtp_word(2, 0, 0, 0, 0, 0, 101), 32'h0000_0010, 16'h0000, 16'd12,
                ST_HDR_LONG, 1'b0, 12, FA_NONE);
      add_typed(rtp_word(2, 0, 0, 0, 0, 0, 101), 32'h0000_0020, 16'h0000, 16'd100,
                ST_DUPLICATE, 1'b0, 0, FA_NONE);
      add_typed(rtp_word(2, 1, 0, 0, 0, 0, 102), 32'h0000_0030, 16'h0000, 16'd100,
                ST_PADDING, 1'b0, 0, FA_NONE);
      add_typed(rtp_word(2, 0, 1, 15, 0, 0, 102), 32'h0000_0040, 16'h0000, 16'd75,
                ST_TRUNC_EXT, 1'b0, 0, FA_NONE);
      // largest header the fields allow
      add_typed(rtp_word(2, 0, 1, 15, 0, 0, 102), 32'h0000_0050, 16'hFFFF, 16'hFFFF,
                ST_HDR_LONG, 1'b0, 262216, FA_NONE);
      add_typed(rtp_word(2, 0, 0, 0, 1, 127, 103), 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
                ST_OK, 1'b1, 12, FA_FINISH);
      // gap invalidates the frame, the marker then cancels it
      add_free(rtp_word(2, 0, 0, 0, 0, 1, 105), 32'h0000_0060, 16'h0000, 16'd200);
      add_free(rtp_word(2, 0, 0, 0, 1, 1, 106), 32'h0000_0070, 16'h0000, 16'd200);
      add_free(rtp_word(2, 0, 1, 2, 0, 1, 107), 32'h8000_0000, 16'h0003, 16'd40);
      // sequence wrap, then a step backwards
      add_free(rtp_word(2, 0, 0, 0, 0, 2, 16'hFFFF), 32'h0000_0080, 16'h0000, 16'd100);
      add_free(rtp_word(2, 0, 0, 0, 1, 2, 0), 32'h0000_0090, 16'h0000, 16'd100);
      add_free(rtp_word(2, 0, 0, 0, 0, 2, 1), 32'h1234_5678, 16'h0000, 16'd100);
      add_free(rtp_word(2, 0, 0, 0, 0, 2, 0), 32'h0000_00A0, 16'h0000, 16'd100);
      add_map(CSR_PT_LOW, 64'h0000_0000_0000_0001);
      add_map(CSR_PT_HIGH, 64'h8000_0000_0000_0000);
      add_typed(rtp_word(2, 0, 0, 0, 1, 64, 1), 32'h0000_00B0, 16'h0000, 16'd100,
                ST_NO_DEC, 1'b0, 12, FA_NONE);
      add_free(rtp_word(2, 0, 0, 0, 1, 127, 2), 32'h0000_00C0, 16'h0000, 16'd100);
      add_free(rtp_word(2, 0, 0, 0, 0, 0, 3), 32'h0000_00D0, 16'h0000, 16'd13);
      add_typed(rtp_word(2, 0, 0, 0, 0, 63, 4), 32'h0000_00E0, 16'h0000, 16'd100,
                ST_NO_DEC, 1'b0, 12, FA_NONE);
      // version bits take no part
      add_free(rtp_word(3, 0, 0, 0, 1, 0, 5), 32'h0000_00F0, 16'h0000, 16'd50);
      add_typed(rtp_word(0, 0, 1, 0, 0, 0, 6), 32'h0000_0100, 16'h0000, 16'd15,
                ST_TRUNC_EXT, 1'b0, 0, FA_NONE);
      add_typed(rtp_word(1, 0, 1, 0, 0, 0, 6), 32'h0000_0110, 16'h0000, 16'd16,
                ST_HDR_LONG, 1'b0, 16, FA_NONE);
      // extension length is ignored with the x bit clear
      add_free(rtp_word(2, 0, 0, 0, 0, 0, 7), 32'h0000_0120, 16'hFFFF, 16'd20);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_MAP) begin
            write_pt_map(directed_rows[i].addr, directed_rows[i].map);
         end else begin
            send_item(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < MapPhases; phase++) begin
         case (phase)
            0: begin
               lo_map = '1;
               hi_map = '1;
            end
            1: begin
               lo_map = '0;
               hi_map = '0;
            end
            3: begin
               lo_map = '0;
               hi_map = '1;
            end
            4: begin
               lo_map = '1;
               hi_map = '0;
            end
            default: begin
               lo_map = {$urandom, $urandom};
               hi_map = {$urandom, $urandom};
            end
         endcase
         write_pt_map(CSR_PT_LOW, lo_map);
         write_pt_map(CSR_PT_HIGH, hi_map);
         for (int n = 0; n < RandomPerPhase; n++) begin
            if (n % 50 == 0) send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            if ($urandom_range(0, 149) == 0) wait_drained();
            // mostly the next packet in order, with duplicates, gaps and jumps mixed in
            sel = $urandom_range(0, 99);
            if (sel < 78) seq = last_seq + 16'd1;
            else if (sel < 84) seq = last_seq;
            else if (sel < 94) seq = last_seq + 16'($urandom_range(2, 6));
            else seq = 16'($urandom);
            cc  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            xb  = ($urandom_range(0, 3) == 0);
            ext = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            hsize_nom = HdrFixed + cc * WordBytes + (xb ? WordBytes + ext * WordBytes : 0);
            sel = $urandom_range(0, 99);
            if (sel < 5) lenv = $urandom_range(0, 11);
            else if (sel < 10) lenv = $urandom_range(0, 65535);
            else if (sel < 20) lenv = hsize_nom + $urandom_range(0, 8) - 4;
            else lenv = hsize_nom + $urandom_range(1, 1400);
            if (lenv > 65535) lenv = 65535;
            if (lenv < 0) lenv = 0;
            pkt.header_word = rtp_word(2'($urandom), $urandom_range(0, 24) == 0, xb, cc,
                                       $urandom_range(0, 4) == 0, 7'($urandom), seq);
            pkt.rtp_time      = $urandom;
            pkt.ext_length    = ext;
            pkt.packet_length = lenv[15:0];
            send_item(pkt, 1'b0, none);
         end
      end

      wait_drained();
      $display("sent %0d packet descriptors across %0d bitmap register writes",
               items_sent, map_writes);
      $display("%0d payloads delivered, %0d packets held back or rejected",
               deliveries, items_sent - deliveries);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
